// File: hdl/usm_pkg.sv
// Shared constants, types and tables for the UV sphere mesh core.
package usm_pkg;

  localparam int MAX_DIV_DEF       = 1024;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN          = 24;

  localparam int CNT_W      = 11;
  localparam int RAD_W      = 16;
  localparam int COL_W      = 16;
  localparam int IDX_W      = 21;
  localparam int POS_W      = 24;
  localparam int NRM_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int ANG_W = 34;
  localparam int QUO_W = 33;
  localparam int NUM_W = QUO_W + CNT_W;
  localparam int MUL_W = 32;

  localparam logic [NUM_W-1:0]        PI_NUM     = NUM_W'(64'd3373259426);
  localparam logic [NUM_W-1:0]        TWO_PI_NUM = NUM_W'(64'd6746518852);
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'sd1686629713);
  localparam logic signed [ANG_W-1:0] GAIN_Q30    = ANG_W'(64'sd652032874);

  localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_INDEX  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STACK_COUNT  = 3'd0,
    REG_SLICE_COUNT  = 3'd1,
    REG_RADIUS       = 3'd2,
    REG_COLOUR_RED   = 3'd3,
    REG_COLOUR_GREEN = 3'd4,
    REG_COLOUR_BLUE  = 3'd5
  } cfg_reg_t;

endpackage

// File: hdl/uv_sphere_mesh_generator_core.sv
// UV sphere tessellation core: vertex and quad index generator.
//
// Input channel (in_valid/in_ready) takes one request word: in_func selects a vertex
// (0) or a quad's six triangle indices (1) at grid point in_stack_index,
// in_slice_index. Output channel (out_valid/out_ready) returns result words;
// out_last_of_run marks the final word of a request.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must write it
// only while the core is idle, as the core itself does not enforce this; indexes above five are ignored.
// The path is one pipeline: an input register, a 33-stage divider for the angles, a fold
// stage, CORDIC_STAGES rotation stages, product, rounding and position stages and an
// output register. A vertex or error request leaves the output register as one word;
// a quad request holds the output register for its six index words, stalling the pipeline.
// Reset loads the default geometry and colour and empties the pipeline.
// When the receiver stalls, the whole pipeline holds and in_ready drops.
module uv_sphere_mesh_generator_core import usm_pkg::*; #(
  parameter int MAX_DIVISIONS = MAX_DIV_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [CNT_W-1:0]             in_stack_index,
  input  logic [CNT_W-1:0]             in_slice_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_result_kind,
  output logic signed [POS_W-1:0]      out_pos_x,
  output logic signed [POS_W-1:0]      out_pos_y,
  output logic signed [POS_W-1:0]      out_pos_z,
  output logic signed [NRM_W-1:0]      out_normal_x,
  output logic signed [NRM_W-1:0]      out_normal_y,
  output logic signed [NRM_W-1:0]      out_normal_z,
  output logic [COL_W-1:0]             out_vert_red,
  output logic [COL_W-1:0]             out_vert_green,
  output logic [COL_W-1:0]             out_vert_blue,
  output logic [IDX_W-1:0]             out_vertex_number,
  output logic                         out_last_of_run
);

  localparam int SB_LEN = QUO_W + CORDIC_STAGES + 5;
  localparam int LIM_W  = CNT_W + 2;
  localparam int TH_W   = ANG_W + 1;
  localparam int BF_W   = 2*CNT_W + 1;
  localparam int PP_W   = 2*MUL_W;
  localparam int RP_W   = RAD_W + NRM_W + 2;
  localparam logic [LIM_W-1:0] DIV_LIM = LIM_W'(MAX_DIVISIONS);
  localparam logic signed [TH_W-1:0] PI_T      = TH_W'(64'sd3373259426);
  localparam logic signed [TH_W-1:0] TWO_PI_T  = TH_W'(64'sd6746518852);
  localparam logic signed [TH_W-1:0] HALF_PI_T = TH_W'(64'sd1686629713);
  localparam logic signed [PP_W-1:0] RND_P = PP_W'(64'sd17592186044416);
  localparam logic [2:0] SEQ_LAST = 3'd5;

  function automatic logic signed [NRM_W-1:0] sat_nrm(input logic signed [PP_W-1:0] v);
    if (v < -PP_W'(64'sd32768)) return NRM_W'(16'sh8000);
    if (v > PP_W'(64'sd32767))  return NRM_W'(16'sh7FFF);
    return v[NRM_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [RP_W-1:0] v);
    if (v < -RP_W'(64'sd8388608)) return POS_W'(24'sh800000);
    if (v > RP_W'(64'sd8388607))  return POS_W'(24'sh7FFFFF);
    return v[POS_W-1:0];
  endfunction

  // configuration
  logic [CNT_W-1:0] stack_count_r, slice_count_r;
  logic [RAD_W-1:0] radius_r;
  logic [COL_W-1:0] red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_count_r <= CNT_W'(16);
      slice_count_r <= CNT_W'(32);
      radius_r      <= RAD_W'(256);
      red_r         <= '1;
      green_r       <= '1;
      blue_r        <= '1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STACK_COUNT:  stack_count_r <= cfg_wdata[CNT_W-1:0];
        REG_SLICE_COUNT:  slice_count_r <= cfg_wdata[CNT_W-1:0];
        REG_RADIUS:       radius_r      <= cfg_wdata[RAD_W-1:0];
        REG_COLOUR_RED:   red_r         <= cfg_wdata[COL_W-1:0];
        REG_COLOUR_GREEN: green_r       <= cfg_wdata[COL_W-1:0];
        REG_COLOUR_BLUE:  blue_r        <= cfg_wdata[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [2:0] seq_cnt_r;
  logic       out_last;
  logic       adv;

  assign out_last = (out_kind_r != KIND_INDEX) || (seq_cnt_r == SEQ_LAST);
  assign adv      = !out_valid_r || (out_ready && out_last);
  assign in_ready = adv && rst_n;

  // input stage
  logic             geom_ok, in_err;
  kind_t            in_kind;
  logic [BF_W-1:0]  base_full;
  logic [NUM_W-1:0] num_phi_r, num_th_r;

  always_comb begin
    geom_ok = (stack_count_r != '0) && ({2'b0, stack_count_r} <= DIV_LIM) &&
              (slice_count_r != '0) && ({2'b0, slice_count_r} <= DIV_LIM);
    if (in_func) begin
      in_err = !geom_ok || (in_stack_index >= stack_count_r) ||
               (in_slice_index >= slice_count_r);
    end else begin
      in_err = !geom_ok || (in_stack_index > stack_count_r) ||
               (in_slice_index > slice_count_r);
    end
    if (in_err) begin
      in_kind = KIND_ERROR;
    end else if (in_func) begin
      in_kind = KIND_INDEX;
    end else begin
      in_kind = KIND_VERTEX;
    end
    base_full = BF_W'(in_stack_index) * BF_W'({1'b0, slice_count_r} + (CNT_W+1)'(1)) +
                BF_W'(in_slice_index);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_phi_r <= PI_NUM * NUM_W'(in_stack_index);
      num_th_r  <= TWO_PI_NUM * NUM_W'(in_slice_index);
    end
  end

  // sideband line
  logic             vld_r  [SB_LEN];
  kind_t            kind_r [SB_LEN];
  logic [IDX_W-1:0] base_r [SB_LEN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '{default: 1'b0};
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k < SB_LEN; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kind_r[0] <= in_kind;
      base_r[0] <= base_full[IDX_W-1:0];
      for (int k = 1; k < SB_LEN; k++) begin
        kind_r[k] <= kind_r[k-1];
        base_r[k] <= base_r[k-1];
      end
    end
  end

  // angle division
  logic [QUO_W-1:0] q_phi, q_th;

  usm_div u_div_phi (
    .clk (clk),
    .en  (adv),
    .num (num_phi_r),
    .den (stack_count_r),
    .quo (q_phi)
  );

  usm_div u_div_th (
    .clk (clk),
    .en  (adv),
    .num (num_th_r),
    .den (slice_count_r),
    .quo (q_th)
  );

  // fold theta into [-pi/2, pi/2]
  logic signed [TH_W-1:0]  th0, th1, th2;
  logic                    fold_neg;
  logic signed [ANG_W-1:0] ang_phi_r, ang_th_r;
  logic                    neg_r [CORDIC_STAGES+1];

  always_comb begin
    th0 = $signed({2'b0, q_th});
    th1 = (th0 > PI_T) ? th0 - TWO_PI_T : th0;
    fold_neg = 1'b0;
    th2 = th1;
    if (th1 > HALF_PI_T) begin
      th2 = th1 - PI_T;
      fold_neg = 1'b1;
    end else if (th1 < -HALF_PI_T) begin
      th2 = th1 + PI_T;
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_phi_r <= $signed({1'b0, q_phi}) - HALF_PI_Q30;
      ang_th_r  <= th2[ANG_W-1:0];
      neg_r[0]  <= fold_neg;
      for (int k = 1; k <= CORDIC_STAGES; k++) begin
        neg_r[k] <= neg_r[k-1];
      end
    end
  end

  // sine and cosine
  logic signed [ANG_W-1:0] phi_cos, phi_sin, th_cos, th_sin;

  usm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_phi (
    .clk   (clk),
    .en    (adv),
    .ang   (ang_phi_r),
    .cos_o (phi_cos),
    .sin_o (phi_sin)
  );

  usm_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_th (
    .clk   (clk),
    .en    (adv),
    .ang   (ang_th_r),
    .cos_o (th_cos),
    .sin_o (th_sin)
  );

  // products
  logic signed [ANG_W-1:0] ct, st;
  logic signed [MUL_W-1:0] ct_m, st_m, sp_m;
  logic signed [PP_W-1:0]  px_r, pz_r;
  logic signed [ANG_W-1:0] cp_r;

  always_comb begin
    ct   = neg_r[CORDIC_STAGES] ? -th_cos : th_cos;
    st   = neg_r[CORDIC_STAGES] ? -th_sin : th_sin;
    ct_m = ct[MUL_W-1:0];
    st_m = st[MUL_W-1:0];
    sp_m = phi_cos[MUL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      px_r <= ct_m * sp_m;
      pz_r <= st_m * sp_m;
      cp_r <= -phi_sin;
    end
  end

  // rounding to Q1.15
  logic signed [NRM_W-1:0] nx_r, ny_r, nz_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_r <= sat_nrm((px_r + RND_P) >>> 45);
      ny_r <= sat_nrm((PP_W'(cp_r) + PP_W'(64'sd16384)) >>> 15);
      nz_r <= sat_nrm((pz_r + RND_P) >>> 45);
    end
  end

  // positions
  logic signed [RP_W-1:0]  rad_s;
  logic signed [POS_W-1:0] px_pos_r, py_pos_r, pz_pos_r;
  logic signed [NRM_W-1:0] nx2_r, ny2_r, nz2_r;

  assign rad_s = $signed({{(RP_W-RAD_W){1'b0}}, radius_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      px_pos_r <= sat_pos((RP_W'(nx_r) * rad_s + RP_W'(128)) >>> 8);
      py_pos_r <= sat_pos((RP_W'(ny_r) * rad_s + RP_W'(128)) >>> 8);
      pz_pos_r <= sat_pos((RP_W'(nz_r) * rad_s + RP_W'(128)) >>> 8);
      nx2_r    <= nx_r;
      ny2_r    <= ny_r;
      nz2_r    <= nz_r;
    end
  end

  // output register
  logic                    is_vtx;
  logic signed [POS_W-1:0] o_px_r, o_py_r, o_pz_r;
  logic signed [NRM_W-1:0] o_nx_r, o_ny_r, o_nz_r;
  logic [COL_W-1:0]        o_red_r, o_green_r, o_blue_r;
  logic [IDX_W-1:0]        o_base_r;
  logic [IDX_W-1:0]        idx_b, idx_c, idx_d, idx_sel;

  assign is_vtx = kind_r[SB_LEN-1] == KIND_VERTEX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      seq_cnt_r   <= '0;
    end else if (adv) begin
      out_valid_r <= vld_r[SB_LEN-1];
      seq_cnt_r   <= '0;
    end else if (out_ready) begin
      seq_cnt_r <= seq_cnt_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_kind_r <= kind_r[SB_LEN-1];
      o_base_r   <= base_r[SB_LEN-1];
      o_px_r     <= is_vtx ? px_pos_r : '0;
      o_py_r     <= is_vtx ? py_pos_r : '0;
      o_pz_r     <= is_vtx ? pz_pos_r : '0;
      o_nx_r     <= is_vtx ? nx2_r : '0;
      o_ny_r     <= is_vtx ? ny2_r : '0;
      o_nz_r     <= is_vtx ? nz2_r : '0;
      o_red_r    <= is_vtx ? red_r : '0;
      o_green_r  <= is_vtx ? green_r : '0;
      o_blue_r   <= is_vtx ? blue_r : '0;
    end
  end

  always_comb begin
    idx_b = o_base_r + IDX_W'(slice_count_r) + IDX_W'(1);
    idx_c = idx_b + IDX_W'(1);
    idx_d = o_base_r + IDX_W'(1);
    case (seq_cnt_r)
      3'd0:    idx_sel = o_base_r;
      3'd1:    idx_sel = idx_b;
      3'd2:    idx_sel = idx_d;
      3'd3:    idx_sel = idx_d;
      3'd4:    idx_sel = idx_b;
      3'd5:    idx_sel = idx_c;
      default: idx_sel = o_base_r;
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_result_kind   = out_kind_r;
  assign out_pos_x         = o_px_r;
  assign out_pos_y         = o_py_r;
  assign out_pos_z         = o_pz_r;
  assign out_normal_x      = o_nx_r;
  assign out_normal_y      = o_ny_r;
  assign out_normal_z      = o_nz_r;
  assign out_vert_red      = o_red_r;
  assign out_vert_green    = o_green_r;
  assign out_vert_blue     = o_blue_r;
  assign out_vertex_number = (out_kind_r == KIND_INDEX) ? idx_sel : '0;
  assign out_last_of_run   = out_last;

  a_seq_only_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_INDEX) |-> seq_cnt_r == '0)
    else $error("index counter moved on a non-index word");

  a_seq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> seq_cnt_r <= SEQ_LAST)
    else $error("index counter beyond last word");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_ERROR) |->
      (out_vertex_number == '0 && o_nx_r == '0 && o_px_r == '0 && out_last))
    else $error("error word carries data");

  a_quad_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !out_last) |=> (out_valid_r && $stable(o_base_r)))
    else $error("quad word lost mid run");

endmodule

// File: hdl/usm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module usm_div import usm_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [CNT_W-1:0] den,
  output logic [QUO_W-1:0] quo
);

  logic [CNT_W-1:0] rem_r [QUO_W-1];
  logic [QUO_W-1:0] low_r [QUO_W-1];
  logic [QUO_W-1:0] q_r   [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [CNT_W-1:0] rem_in;
    logic [QUO_W-1:0] low_in;
    logic [QUO_W-1:0] q_in;
    logic [CNT_W:0]   t;
    logic [CNT_W:0]   diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num[NUM_W-1:QUO_W];
      assign low_in = num[QUO_W-1:0];
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign q_in   = q_r[k-1];
    end

    assign t    = {rem_in, low_in[QUO_W-1]};
    assign ge   = t >= {1'b0, den};
    assign diff = t - {1'b0, den};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {q_in[QUO_W-2:0], ge};
      end
    end

    if (k < QUO_W-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[CNT_W-1:0] : t[CNT_W-1:0];
          low_r[k] <= {low_in[QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[QUO_W-1];

endmodule

// File: hdl/usm_cordic.sv
// Pipelined rotation-mode CORDIC, one micro-rotation per stage.
module usm_cordic import usm_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] ang,
  output logic signed [ANG_W-1:0] cos_o,
  output logic signed [ANG_W-1:0] sin_o
);

  logic signed [ANG_W-1:0] x_r [STAGES];
  logic signed [ANG_W-1:0] y_r [STAGES];
  logic signed [ANG_W-1:0] z_r [STAGES-1];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic signed [ANG_W-1:0] x_in, y_in, z_in, atan_k;

    if (k == 0) begin : g_first
      assign x_in = GAIN_Q30;
      assign y_in = '0;
      assign z_in = ang;
    end else begin : g_next
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign z_in = z_r[k-1];
    end

    assign atan_k = $signed({{(ANG_W-32){1'b0}}, ATAN_Q30[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        if (z_in >= 0) begin
          x_r[k] <= x_in - (y_in >>> k);
          y_r[k] <= y_in + (x_in >>> k);
        end else begin
          x_r[k] <= x_in + (y_in >>> k);
          y_r[k] <= y_in - (x_in >>> k);
        end
      end
    end

    if (k < STAGES-1) begin : g_angle
      always_ff @(posedge clk) begin
        if (en) begin
          z_r[k] <= (z_in >= 0) ? z_in - atan_k : z_in + atan_k;
        end
      end
    end
  end

  assign cos_o = x_r[STAGES-1];
  assign sin_o = y_r[STAGES-1];

endmodule
